/* rtl/maf_pkg.sv */
// shared constants and types of the moving average filter
package maf_pkg;

	// sizing of the delay line and the sample format
	localparam int MAX_WINDOW  = 128;
	localparam int SAMPLE_BITS = 24;
	localparam int ADDR_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int COUNT_W     = $clog2(MAX_WINDOW + 1);
	localparam int SUM_W       = SAMPLE_BITS + ADDR_W;
	localparam int STEP_W      = $clog2(SUM_W);

	// configuration register file
	localparam int WL_W                        = 8;
	localparam logic [WL_W-1:0] WINDOW_RESET   = 8'd100;
	localparam int APB_ADDR_W                  = 3;
	localparam int APB_DATA_W                  = 32;
	localparam int REG_IDX_W                   = APB_ADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'b0;

	// request to the sequential divider
	typedef struct packed {
		logic                    start;
		logic signed [SUM_W-1:0] dividend;
		logic [COUNT_W-1:0]      divisor;
	} div_req_t;

	// control states of the top level
	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_UPDATE = 3'b010,
		ST_DIVIDE = 3'b100
	} maf_state_t;

endpackage

/* rtl/maf_if.sv */
// valid/ready channel interfaces for samples and means
interface maf_in_if import maf_pkg::*;;
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          start_of_sequence;

	modport source (output valid, output sample, output start_of_sequence, input ready);
	modport sink (input valid, input sample, input start_of_sequence, output ready);
endinterface

interface maf_out_if import maf_pkg::*;;
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] mean;

	modport source (output valid, output mean, input ready);
	modport sink (input valid, input mean, output ready);
endinterface

/* rtl/moving_average_filter.sv */
// top level of the moving average filter: control, running sum, config port
//
// Usage: samples arrive on the in_ch channel (valid/ready), one signed
// fixed-point sample with 8 fraction bits and a start_of_sequence flag per
// transaction. Each sample yields one transaction on out_ch carrying the mean
// of the last min(window, samples seen) samples, truncated toward zero.
// The window length is written through the APB port at byte address 0
// (values 0 and 1 both mean one sample, values above 128 act as 128); a write
// also begins a new sequence. Write it only while the block is idle.
// Each item goes through these steps in order: the leaving sample is read at
// acceptance, the sum is updated and the ram written, the divider is loaded,
// the restoring divider runs (one quotient bit per cycle over the 31-bit sum)
// and the output register is loaded. One item is worked on at a time; the
// next sample is taken the cycle after the result is loaded, not before.
// Reset (arst_n low) clears the sum, count, write slot and output valid and
// sets the window length to 100. The delay line needs no clearing.
// When the receiver stalls, the result waits in the output register; a
// following result holds in the divider until that register is freed.
module moving_average_filter import maf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	maf_in_if.sink                in_ch,
	maf_out_if.source             out_ch
);

	maf_state_t state_q;

	logic [WL_W-1:0]               wl_q;
	logic signed [SUM_W-1:0]       sum_q;
	logic [COUNT_W-1:0]            filled_q;
	logic [ADDR_W-1:0]             slot_q;
	logic signed [SAMPLE_BITS-1:0] sample_s1;
	logic                          div_start_q;
	logic signed [SAMPLE_BITS-1:0] mean_q;
	logic                          out_valid_q;

	logic                          cfg_write;
	logic                          in_fire;
	logic                          out_fire;
	logic                          seq_clear;
	logic [COUNT_W-1:0]            eff_w;
	logic [ADDR_W-1:0]             slot_use;
	logic [COUNT_W:0]              old_sum;
	logic [COUNT_W:0]              old_wrap;
	logic [ADDR_W-1:0]             old_addr;
	logic [SAMPLE_BITS-1:0]        ram_rdata;
	logic                          full;
	logic signed [SUM_W-1:0]       sample_ext;
	logic signed [SUM_W-1:0]       leave_ext;
	logic                          ram_we;
	logic                          div_busy;
	logic signed [SAMPLE_BITS-1:0] div_quot;
	logic                          result_load;
	div_req_t                      div_req;

	// apb register access
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite
		&& (paddr[APB_ADDR_W-1:2] == REG_WINDOW_LENGTH);

	always_comb begin
		prdata = '0;
		if (paddr[APB_ADDR_W-1:2] == REG_WINDOW_LENGTH) begin
			prdata[WL_W-1:0] = wl_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q <= WINDOW_RESET;
		end else if (cfg_write) begin
			wl_q <= pwdata[WL_W-1:0];
		end
	end

	// effective window, clamped to one..maximum
	always_comb begin
		if (wl_q == '0) begin
			eff_w = COUNT_W'(1);
		end else if (32'(wl_q) > MAX_WINDOW) begin
			eff_w = COUNT_W'(MAX_WINDOW);
		end else begin
			eff_w = COUNT_W'(wl_q);
		end
	end

	// handshakes
	assign in_fire      = in_ch.valid && in_ch.ready;
	assign out_fire     = out_valid_q && out_ch.ready;
	assign in_ch.ready  = (state_q == ST_IDLE);
	assign out_ch.valid = out_valid_q;
	assign out_ch.mean  = mean_q;

	// slot of the sample leaving the window
	assign slot_use = in_ch.start_of_sequence ? '0 : slot_q;
	always_comb begin
		old_sum  = (COUNT_W + 1)'(slot_use) + (COUNT_W + 1)'(MAX_WINDOW)
			- (COUNT_W + 1)'(eff_w);
		old_wrap = old_sum;
		if (old_sum >= (COUNT_W + 1)'(MAX_WINDOW)) begin
			old_wrap = old_sum - (COUNT_W + 1)'(MAX_WINDOW);
		end
		old_addr = old_wrap[ADDR_W-1:0];
	end

	// sum update operands
	assign full       = (filled_q >= eff_w);
	assign sample_ext = {{ADDR_W{sample_s1[SAMPLE_BITS-1]}}, sample_s1};
	assign leave_ext  = full ? {{ADDR_W{ram_rdata[SAMPLE_BITS-1]}}, ram_rdata} : '0;
	assign ram_we     = (state_q == ST_UPDATE);

	// delay line
	maf_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (MAX_WINDOW)
	) u_history (
		.clk   (clk),
		.we    (ram_we),
		.waddr (slot_q),
		.wdata (sample_s1),
		.re    (in_fire),
		.raddr (old_addr),
		.rdata (ram_rdata)
	);

	// divider
	assign div_req.start    = div_start_q;
	assign div_req.dividend = sum_q;
	assign div_req.divisor  = filled_q;

	maf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.busy     (div_busy),
		.quotient (div_quot)
	);

	assign result_load = (state_q == ST_DIVIDE) && !div_start_q && !div_busy
		&& (!out_valid_q || out_ch.ready);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					state_q <= ST_DIVIDE;
				end
				ST_DIVIDE: begin
					if (result_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// divider kick and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_start_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			div_start_q <= (state_q == ST_UPDATE);
			if (result_load) begin
				out_valid_q <= 1'b1;
			end else if (out_fire) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// running sum, warm-up count and write slot
	assign seq_clear = cfg_write || (in_fire && in_ch.start_of_sequence);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q    <= '0;
			filled_q <= '0;
			slot_q   <= '0;
		end else if (seq_clear) begin
			sum_q    <= '0;
			filled_q <= '0;
			slot_q   <= '0;
		end else if (state_q == ST_UPDATE) begin
			sum_q <= sum_q + sample_ext - leave_ext;
			if (!full) begin
				filled_q <= filled_q + 1'b1;
			end
			if (slot_q == ADDR_W'(MAX_WINDOW - 1)) begin
				slot_q <= '0;
			end else begin
				slot_q <= slot_q + 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			sample_s1 <= in_ch.sample;
		end
		if (result_load) begin
			mean_q <= div_quot;
		end
	end

endmodule

/* rtl/maf_ram.sv */
// generic single-port-write, single-port-read ram with registered read data
module maf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/maf_div.sv */
// restoring radix-2 divider: signed running sum over unsigned sample count
module maf_div import maf_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  div_req_t                      req,
	output logic                          busy,
	output logic signed [SAMPLE_BITS-1:0] quotient
);

	logic [SUM_W-1:0]   quot_q;
	logic [COUNT_W-1:0] rem_q;
	logic [COUNT_W-1:0] divisor_q;
	logic               neg_q;
	logic [STEP_W-1:0]  cnt_q;
	logic               busy_q;

	logic [SUM_W-1:0]   magnitude;
	logic [COUNT_W:0]   rem_shift;
	logic [COUNT_W:0]   rem_diff;
	logic               fits;
	logic [SUM_W-1:0]   signed_quot;

	// magnitude of the dividend
	assign magnitude = req.dividend[SUM_W-1] ? (~req.dividend + 1'b1) : req.dividend;

	// one quotient bit per cycle
	always_comb begin
		rem_shift = {rem_q, quot_q[SUM_W-1]};
		rem_diff  = rem_shift - {1'b0, divisor_q};
		fits      = (rem_shift >= {1'b0, divisor_q});
	end

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= STEP_W'(SUM_W - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (req.start) begin
			quot_q    <= magnitude;
			rem_q     <= '0;
			divisor_q <= req.divisor;
			neg_q     <= req.dividend[SUM_W-1];
		end else if (busy_q) begin
			quot_q <= {quot_q[SUM_W-2:0], fits};
			rem_q  <= fits ? rem_diff[COUNT_W-1:0] : rem_shift[COUNT_W-1:0];
		end
	end

	// restore the sign, truncation toward zero falls out of the magnitude division
	assign signed_quot = neg_q ? (~quot_q + 1'b1) : quot_q;
	assign quotient    = signed_quot[SAMPLE_BITS-1:0];
	assign busy        = busy_q;

endmodule
